// ===== design/assert_macros.svh =====
// Assertion macros shared by the bus master copy sequencer modules.
// No dependencies; files that assert include this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bmctt_pkg.sv =====
// Types and constants of the bus master copy sequencer.
// No dependencies; used by the sequencer, the result queue and the top level.
package bmctt_pkg;

    // Slave response codes.
    typedef enum logic [1:0] {
        ACK_WAIT  = 2'd0,
        ACK_READY = 2'd1,
        ACK_ERROR = 2'd2,
        ACK_RETRY = 2'd3
    } t_ack;

    // Configuration register indexes (byte address bits 3:2).
    localparam logic [1:0] REG_RAM_BASE    = 2'd0;
    localparam logic [1:0] REG_TTY_BASE    = 2'd1;
    localparam logic [1:0] REG_WORD_OPCODE = 2'd2;

    localparam logic [31:0] BASE_MASK     = 32'hFFFF_FFFC;
    localparam logic [31:0] STATUS_OFFSET = 32'd4;
    localparam logic [31:0] DATA_OFFSET   = 32'd8;

    // Phase numbers as reported on the phase output.
    localparam logic [4:0] PH_INIT      = 5'd0;
    localparam logic [4:0] PH_RAM_REQ   = 5'd1;
    localparam logic [4:0] PH_RAM_A0    = 5'd2;
    localparam logic [4:0] PH_RAM_FIRST = 5'd3;
    localparam logic [4:0] PH_RAM_MID   = 5'd4;
    localparam logic [4:0] PH_RAM_LAST  = 5'd5;
    localparam logic [4:0] PH_RAM_DLAST = 5'd6;
    localparam logic [4:0] PH_WR_REQ    = 5'd7;
    localparam logic [4:0] PH_WR_AD     = 5'd8;
    localparam logic [4:0] PH_WR_DT     = 5'd9;
    localparam logic [4:0] PH_ST_REQ    = 5'd10;
    localparam logic [4:0] PH_ST_AD     = 5'd11;
    localparam logic [4:0] PH_ST_DT     = 5'd12;
    localparam logic [4:0] PH_BF_REQ    = 5'd13;
    localparam logic [4:0] PH_BF_AD     = 5'd14;
    localparam logic [4:0] PH_BF_DT     = 5'd15;
    localparam logic [4:0] PH_HALT      = 5'd16;

    typedef enum logic [16:0] {
        ST_INIT      = 17'h00001,
        ST_RAM_REQ   = 17'h00002,
        ST_RAM_A0    = 17'h00004,
        ST_RAM_FIRST = 17'h00008,
        ST_RAM_MID   = 17'h00010,
        ST_RAM_LAST  = 17'h00020,
        ST_RAM_DLAST = 17'h00040,
        ST_WR_REQ    = 17'h00080,
        ST_WR_AD     = 17'h00100,
        ST_WR_DT     = 17'h00200,
        ST_ST_REQ    = 17'h00400,
        ST_ST_AD     = 17'h00800,
        ST_ST_DT     = 17'h01000,
        ST_BF_REQ    = 17'h02000,
        ST_BF_AD     = 17'h04000,
        ST_BF_DT     = 17'h08000,
        ST_HALT      = 17'h10000
    } t_phase;

    typedef struct packed {
        logic        grant;
        logic [1:0]  ack_code;
        logic        timeout;
        logic [31:0] read_data;
    } t_bus_in;

    typedef struct packed {
        logic [31:0] ram_base;
        logic [31:0] tty_base;
        logic [3:0]  word_opcode;
    } t_cfg;

    typedef struct packed {
        logic        request;
        logic [31:0] address;
        logic [3:0]  opcode;
        logic        read_flag;
        logic        lock_flag;
        logic [7:0]  write_data;
        logic        error_halt;
        logic [4:0]  phase;
    } t_result;

    function automatic logic [4:0] phase_code(input t_phase st);
        logic [4:0] code;
        unique case (st)
            ST_INIT:      code = PH_INIT;
            ST_RAM_REQ:   code = PH_RAM_REQ;
            ST_RAM_A0:    code = PH_RAM_A0;
            ST_RAM_FIRST: code = PH_RAM_FIRST;
            ST_RAM_MID:   code = PH_RAM_MID;
            ST_RAM_LAST:  code = PH_RAM_LAST;
            ST_RAM_DLAST: code = PH_RAM_DLAST;
            ST_WR_REQ:    code = PH_WR_REQ;
            ST_WR_AD:     code = PH_WR_AD;
            ST_WR_DT:     code = PH_WR_DT;
            ST_ST_REQ:    code = PH_ST_REQ;
            ST_ST_AD:     code = PH_ST_AD;
            ST_ST_DT:     code = PH_ST_DT;
            ST_BF_REQ:    code = PH_BF_REQ;
            ST_BF_AD:     code = PH_BF_AD;
            ST_BF_DT:     code = PH_BF_DT;
            default:      code = PH_HALT;
        endcase
        return code;
    endfunction

endpackage

// ===== design/bmctt_seq.sv =====
// Program sequencer: state, held bus outputs and the burst word buffer.
// Depends on bmctt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bmctt_seq import bmctt_pkg::*; #(
    parameter int BURST_WORDS = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_bus_in i_bus,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam int WIDX = (BURST_WORDS > 1) ? $clog2(BURST_WORDS) : 1;
    localparam int BCW  = $clog2(4 * BURST_WORDS + 1);
    localparam logic [BCW-1:0]  LAST_BYTE = BCW'(4 * BURST_WORDS - 1);
    localparam logic [WIDX:0]   BW_W      = (WIDX + 1)'(BURST_WORDS);
    localparam logic [BCW-3:0]  BW_B      = (BCW - 2)'(BURST_WORDS);
    localparam logic [WIDX-1:0] LAST_WORD = WIDX'(BURST_WORDS - 1);

    t_phase          r_state, n_state;
    logic [BCW-1:0]  r_bc, n_bc;
    logic [WIDX-1:0] r_bidx, n_bidx;
    logic [31:0]     r_addr, n_addr;
    logic [3:0]      r_op, n_op;
    logic            r_rd, n_rd;
    logic            r_lk, n_lk;
    logic [7:0]      r_wb, n_wb;
    logic [31:0]     r_buf [BURST_WORDS];

    logic            drv;
    logic [31:0]     drv_addr;
    logic            drv_rd;
    logic            drv_lk;
    logic            wr_en;
    logic [WIDX-1:0] wr_idx;
    logic [WIDX:0]   bidx_inc;
    logic [BCW-3:0]  rd_word;
    logic [31:0]     sel_word;
    logic            ack_ready;
    logic            failed;

    function automatic t_phase burst_phase(input logic [WIDX:0] k);
        t_phase ph;
        if (k + (WIDX + 1)'(1) >= BW_W) begin
            ph = ST_RAM_LAST;
        end else if (k == (WIDX + 1)'(1)) begin
            ph = ST_RAM_FIRST;
        end else begin
            ph = ST_RAM_MID;
        end
        return ph;
    endfunction

    assign bidx_inc  = {1'b0, r_bidx} + (WIDX + 1)'(1);
    assign rd_word   = r_bc[BCW-1:2];
    assign sel_word  = (rd_word < BW_B) ? r_buf[rd_word[WIDX-1:0]] : 32'd0;
    assign ack_ready = (i_bus.ack_code == ACK_READY);
    // Ready wins over a timeout flagged in the same cycle.
    assign failed    = (i_bus.ack_code == ACK_ERROR) || (i_bus.ack_code == ACK_RETRY)
                       || i_bus.timeout;

    always_comb begin
        n_state  = r_state;
        n_bc     = r_bc;
        n_bidx   = r_bidx;
        n_wb     = r_wb;
        drv      = 1'b0;
        drv_addr = r_addr;
        drv_rd   = r_rd;
        drv_lk   = r_lk;
        wr_en    = 1'b0;
        wr_idx   = LAST_WORD;
        unique case (r_state)
            ST_INIT: begin
                n_bc    = '0;
                n_state = ST_RAM_REQ;
            end
            ST_RAM_REQ: begin
                if (i_bus.grant) n_state = ST_RAM_A0;
            end
            ST_RAM_A0: begin
                drv      = 1'b1;
                drv_addr = i_cfg.ram_base;
                drv_rd   = 1'b1;
                drv_lk   = (BURST_WORDS > 1);
                if (BURST_WORDS > 1) begin
                    n_bidx  = WIDX'(1);
                    n_state = burst_phase((WIDX + 1)'(1));
                end else begin
                    n_state = ST_RAM_DLAST;
                end
            end
            ST_RAM_FIRST, ST_RAM_MID, ST_RAM_LAST: begin
                // Address of word r_bidx goes out while data of the word before returns.
                drv      = 1'b1;
                drv_addr = i_cfg.ram_base + 32'({r_bidx, 2'b00});
                drv_rd   = 1'b1;
                drv_lk   = (bidx_inc < BW_W);
                if (ack_ready) begin
                    wr_en  = 1'b1;
                    wr_idx = r_bidx - WIDX'(1);
                    if (bidx_inc < BW_W) begin
                        n_bidx  = bidx_inc[WIDX-1:0];
                        n_state = burst_phase(bidx_inc);
                    end else begin
                        n_state = ST_RAM_DLAST;
                    end
                end else if (failed) begin
                    n_state = ST_HALT;
                end
            end
            ST_RAM_DLAST: begin
                if (ack_ready) begin
                    wr_en   = 1'b1;
                    wr_idx  = LAST_WORD;
                    n_state = ST_WR_REQ;
                end else if (failed) begin
                    n_state = ST_HALT;
                end
            end
            ST_WR_REQ: begin
                if (i_bus.grant) n_state = ST_WR_AD;
            end
            ST_WR_AD: begin
                drv      = 1'b1;
                drv_addr = i_cfg.tty_base;
                drv_rd   = 1'b0;
                drv_lk   = 1'b0;
                n_state  = ST_WR_DT;
            end
            ST_WR_DT: begin
                n_wb = sel_word[{r_bc[1:0], 3'b000} +: 8];
                if (ack_ready) begin
                    n_state = (r_bc >= LAST_BYTE) ? ST_ST_REQ : ST_WR_REQ;
                    n_bc    = r_bc + BCW'(1);
                end else if (failed) begin
                    n_state = ST_HALT;
                end
            end
            ST_ST_REQ: begin
                if (i_bus.grant) n_state = ST_ST_AD;
            end
            ST_ST_AD: begin
                drv      = 1'b1;
                drv_addr = i_cfg.tty_base + STATUS_OFFSET;
                drv_rd   = 1'b1;
                drv_lk   = 1'b0;
                n_state  = ST_ST_DT;
            end
            ST_ST_DT: begin
                if (ack_ready) begin
                    n_state = (i_bus.read_data == 32'd0) ? ST_ST_REQ : ST_BF_REQ;
                end else if (failed) begin
                    n_state = ST_HALT;
                end
            end
            ST_BF_REQ: begin
                if (i_bus.grant) n_state = ST_BF_AD;
            end
            ST_BF_AD: begin
                drv      = 1'b1;
                drv_addr = i_cfg.tty_base + DATA_OFFSET;
                drv_rd   = 1'b1;
                drv_lk   = 1'b0;
                n_state  = ST_BF_DT;
            end
            ST_BF_DT: begin
                // The data register read only ever ends on a ready response.
                if (ack_ready) n_state = ST_INIT;
            end
            default: begin
                n_state = ST_HALT;
            end
        endcase
    end

    always_comb begin
        n_addr = drv ? drv_addr : r_addr;
        n_op   = drv ? i_cfg.word_opcode : r_op;
        n_rd   = drv ? drv_rd : r_rd;
        n_lk   = drv ? drv_lk : r_lk;
    end

    // The result shows the bus outputs as driven during this transaction's cycle.
    always_comb begin
        o_result.request    = (r_state == ST_RAM_REQ) || (r_state == ST_WR_REQ)
                              || (r_state == ST_ST_REQ) || (r_state == ST_BF_REQ);
        o_result.address    = n_addr;
        o_result.opcode     = n_op;
        o_result.read_flag  = n_rd;
        o_result.lock_flag  = n_lk;
        o_result.write_data = n_wb;
        o_result.error_halt = (r_state == ST_HALT);
        o_result.phase      = phase_code(r_state);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_bc    <= '0;
            r_bidx  <= '0;
            r_addr  <= '0;
            r_op    <= '0;
            r_rd    <= 1'b0;
            r_lk    <= 1'b0;
            r_wb    <= '0;
        end else if (i_step) begin
            r_state <= n_state;
            r_bc    <= n_bc;
            r_bidx  <= n_bidx;
            r_addr  <= n_addr;
            r_op    <= n_op;
            r_rd    <= n_rd;
            r_lk    <= n_lk;
            r_wb    <= n_wb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && wr_en) begin
            r_buf[wr_idx] <= i_bus.read_data;
        end
    end

    `ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, r_state == ST_HALT, r_state == ST_HALT, "halt left")
    `ASSERT_NEXT(a_hold_idle, i_clk, i_rst_n, !i_step, $stable(r_state), "state moved without transaction")
    `ASSERT_IMPL(a_byte_range, i_clk, i_rst_n, r_state == ST_WR_DT, r_bc <= LAST_BYTE, "byte count past end")

endmodule

// ===== design/bmctt_out_buf.sv =====
// Two-entry result queue between the sequencer and the output channel.
// Depends on bmctt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bmctt_out_buf import bmctt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_pop,
    output t_result o_data
);

    t_result    r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_pop;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (pop) r_rd_ptr <= ~r_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, r_count == 2'd2, !i_push, "push into full queue")

endmodule

// ===== design/bus_master_copy_to_tty_unit.sv =====
// Top level of the bus master copy sequencer: configuration port and channels.
// Depends on bmctt_pkg, bmctt_seq and bmctt_out_buf.

// Each input transaction is one bus clock cycle (grant, response, timeout and read
// data), and each produces exactly one result transaction describing the bus outputs
// of that same cycle. A transaction is accepted every clock cycle while the two-entry
// result queue has room; queued results are offered in order. The sequencer runs
// a fixed program: a locked burst read of BURST_WORDS words from ram_base, one
// terminal write per byte, lowest byte first, a status poll at tty_base+4 until
// nonzero, and a read of tty_base+8, then repeats. An error, retry or timeout
// response during a burst, write or status data phase halts the block until reset.
// Configuration registers sit at byte addresses 0 (ram_base), 4 (tty_base) and
// 8 (word_opcode); the low two bits of both base addresses read back as zero.
module bus_master_copy_to_tty_unit import bmctt_pkg::*; #(
    parameter int BURST_WORDS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_grant,
    input  logic [1:0]  i_ack_code,
    input  logic        i_timeout,
    input  logic [31:0] i_read_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_request,
    output logic [31:0] o_address,
    output logic [3:0]  o_opcode,
    output logic        o_read_flag,
    output logic        o_lock_flag,
    output logic [7:0]  o_write_data,
    output logic        o_error_halt,
    output logic [4:0]  o_phase
);

    t_cfg    r_cfg;
    t_bus_in bus;
    t_result seq_result;
    t_result out_data;
    logic    q_full;
    logic    step;
    logic    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_RAM_BASE:    r_cfg.ram_base    <= pwdata & BASE_MASK;
                REG_TTY_BASE:    r_cfg.tty_base    <= pwdata & BASE_MASK;
                REG_WORD_OPCODE: r_cfg.word_opcode <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_RAM_BASE:    prdata = r_cfg.ram_base;
            REG_TTY_BASE:    prdata = r_cfg.tty_base;
            REG_WORD_OPCODE: prdata = {28'd0, r_cfg.word_opcode};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_ready = !q_full;
    assign step    = i_valid && o_ready;

    assign bus.grant     = i_grant;
    assign bus.ack_code  = i_ack_code;
    assign bus.timeout   = i_timeout;
    assign bus.read_data = i_read_data;

    bmctt_seq #(
        .BURST_WORDS(BURST_WORDS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_bus    (bus),
        .i_cfg    (r_cfg),
        .o_result (seq_result)
    );

    bmctt_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_data  (seq_result),
        .o_full  (q_full),
        .o_valid (o_valid),
        .i_pop   (i_ready),
        .o_data  (out_data)
    );

    assign o_request    = out_data.request;
    assign o_address    = out_data.address;
    assign o_opcode     = out_data.opcode;
    assign o_read_flag  = out_data.read_flag;
    assign o_lock_flag  = out_data.lock_flag;
    assign o_write_data = out_data.write_data;
    assign o_error_halt = out_data.error_halt;
    assign o_phase      = out_data.phase;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for bus_master_copy_to_tty_unit: random bus responses,
// APB register writes between traffic phases, and a cycle-accurate output predictor.
// Depends on bmctt_pkg and the bus_master_copy_to_tty_unit RTL.
module tb;
    import bmctt_pkg::*;

    localparam int BURST_WORDS = 4;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Predicts the bus outputs of every accepted cycle and checks the results in order.
    class bus_master_scoreboard;
        logic [31:0] ram_base;
        logic [31:0] tty_base;
        logic [3:0]  word_opcode;
        logic [4:0]  phase;
        logic [4:0]  byte_count;
        int unsigned burst_index;
        logic [31:0] buffered[BURST_WORDS];
        logic [31:0] address_q;
        logic [3:0]  opcode_q;
        logic        read_q;
        logic        lock_q;
        logic [7:0]  byte_q;
        int unsigned mismatches;
        t_result     expected_outputs[$];

        function new();
            ram_base = '0;
            tty_base = '0;
            word_opcode = '0;
            phase = PH_INIT;
            byte_count = '0;
            burst_index = 0;
            foreach (buffered[k]) buffered[k] = '0;
            address_q = '0;
            opcode_q = '0;
            read_q = 1'b0;
            lock_q = 1'b0;
            byte_q = '0;
            mismatches = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] value);
            if (idx == REG_RAM_BASE) ram_base = value & BASE_MASK;
            else if (idx == REG_TTY_BASE) tty_base = value & BASE_MASK;
            else if (idx == REG_WORD_OPCODE) word_opcode = value[3:0];
        endfunction

        function logic [4:0] phase_now();
            return phase;
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction

        function logic [4:0] burst_phase(int unsigned k);
            if (k + 1 >= BURST_WORDS) return PH_RAM_LAST;
            if (k == 1) return PH_RAM_FIRST;
            return PH_RAM_MID;
        endfunction

        function void latch_address(logic [31:0] addr, logic rd, logic lk);
            address_q = addr;
            opcode_q = word_opcode;
            read_q = rd;
            lock_q = lk;
        endfunction

        // Outputs follow the phase held before the cycle; the phase then advances.
        function t_result predict_bus_outputs(t_bus_in it);
            t_result r;
            logic [4:0] cur;
            logic bad;
            cur = phase;
            bad = it.ack_code == ACK_ERROR || it.ack_code == ACK_RETRY || it.timeout;
            case (cur)
                PH_RAM_A0: latch_address(ram_base, 1'b1, BURST_WORDS > 1);
                PH_RAM_FIRST, PH_RAM_MID, PH_RAM_LAST:
                    latch_address(ram_base + 32'(4 * burst_index), 1'b1,
                                  burst_index + 1 < BURST_WORDS);
                PH_WR_AD: latch_address(tty_base, 1'b0, 1'b0);
                PH_ST_AD: latch_address(tty_base + STATUS_OFFSET, 1'b1, 1'b0);
                PH_BF_AD: latch_address(tty_base + DATA_OFFSET, 1'b1, 1'b0);
                PH_WR_DT: byte_q = 8'(buffered[byte_count[3:2]] >> (8 * byte_count[1:0]));
                default: ;
            endcase

            r.request = cur == PH_RAM_REQ || cur == PH_WR_REQ ||
                        cur == PH_ST_REQ || cur == PH_BF_REQ;
            r.address = address_q;
            r.opcode = opcode_q;
            r.read_flag = read_q;
            r.lock_flag = lock_q;
            r.write_data = byte_q;
            r.error_halt = cur == PH_HALT;
            r.phase = cur;

            case (cur)
                PH_INIT: begin
                    byte_count = '0;
                    phase = PH_RAM_REQ;
                end
                PH_RAM_REQ: if (it.grant) phase = PH_RAM_A0;
                PH_RAM_A0: begin
                    if (BURST_WORDS > 1) begin
                        burst_index = 1;
                        phase = burst_phase(1);
                    end else begin
                        phase = PH_RAM_DLAST;
                    end
                end
                PH_RAM_FIRST, PH_RAM_MID, PH_RAM_LAST: begin
                    if (it.ack_code == ACK_READY) begin
                        buffered[burst_index - 1] = it.read_data;
                        if (burst_index + 1 < BURST_WORDS) begin
                            burst_index++;
                            phase = burst_phase(burst_index);
                        end else begin
                            phase = PH_RAM_DLAST;
                        end
                    end else if (bad) begin
                        phase = PH_HALT;
                    end
                end
                PH_RAM_DLAST: begin
                    if (it.ack_code == ACK_READY) begin
                        buffered[BURST_WORDS - 1] = it.read_data;
                        phase = PH_WR_REQ;
                    end else if (bad) begin
                        phase = PH_HALT;
                    end
                end
                PH_WR_REQ: if (it.grant) phase = PH_WR_AD;
                PH_WR_AD: phase = PH_WR_DT;
                PH_WR_DT: begin
                    if (it.ack_code == ACK_READY) begin
                        phase = (byte_count >= 4 * BURST_WORDS - 1) ? PH_ST_REQ : PH_WR_REQ;
                        byte_count++;
                    end else if (bad) begin
                        phase = PH_HALT;
                    end
                end
                PH_ST_REQ: if (it.grant) phase = PH_ST_AD;
                PH_ST_AD: phase = PH_ST_DT;
                PH_ST_DT: begin
                    if (it.ack_code == ACK_READY) begin
                        phase = (it.read_data == 0) ? PH_ST_REQ : PH_BF_REQ;
                    end else if (bad) begin
                        phase = PH_HALT;
                    end
                end
                PH_BF_REQ: if (it.grant) phase = PH_BF_AD;
                PH_BF_AD: phase = PH_BF_DT;
                PH_BF_DT: if (it.ack_code == ACK_READY) phase = PH_INIT;
                default: phase = PH_HALT;
            endcase
            return r;
        endfunction

        function void note_cycle(t_bus_in it);
            expected_outputs.push_back(predict_bus_outputs(it));
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10) $display("mismatch on %s: expected %h, got %h", what, want, got);
        endfunction

        function void check_outputs(t_result got);
            t_result want;
            if (expected_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result transaction with nothing expected");
                return;
            end
            want = expected_outputs.pop_front();
            if (got.request !== want.request) report("request", want.request, got.request);
            if (got.address !== want.address) report("address", want.address, got.address);
            if (got.opcode !== want.opcode) report("opcode", want.opcode, got.opcode);
            if (got.read_flag !== want.read_flag)
                report("read_flag", want.read_flag, got.read_flag);
            if (got.lock_flag !== want.lock_flag)
                report("lock_flag", want.lock_flag, got.lock_flag);
            if (got.write_data !== want.write_data)
                report("write_data", want.write_data, got.write_data);
            if (got.error_halt !== want.error_halt)
                report("error_halt", want.error_halt, got.error_halt);
            if (got.phase !== want.phase) report("phase", want.phase, got.phase);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_grant = 1'b0;
    logic [1:0]  i_ack_code = '0;
    logic        i_timeout = 1'b0;
    logic [31:0] i_read_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_request;
    logic [31:0] o_address;
    logic [3:0]  o_opcode;
    logic        o_read_flag;
    logic        o_lock_flag;
    logic [7:0]  o_write_data;
    logic        o_error_halt;
    logic [4:0]  o_phase;

    bus_master_scoreboard sb;
    bit no_idle = 1'b0;
    bit hold_ask = 1'b0;
    int hold_left = 0;

    // Walks from reset through the burst read into the first byte writes, with
    // field extremes, ignored responses outside data phases and ready beating timeout.
    t_bus_in opening_seq[18] = '{
        {1'b0, ACK_ERROR, 1'b1, 32'h0000_0000},
        {1'b0, ACK_RETRY, 1'b1, 32'hFFFF_FFFF},
        {1'b1, ACK_WAIT,  1'b0, 32'h0000_0000},
        {1'b0, ACK_ERROR, 1'b1, 32'h0000_0000},
        {1'b1, ACK_WAIT,  1'b0, 32'hFFFF_FFFF},
        {1'b0, ACK_READY, 1'b1, 32'hFFFF_FFFF},
        {1'b1, ACK_READY, 1'b0, 32'h0000_0000},
        {1'b0, ACK_WAIT,  1'b0, 32'h8000_0001},
        {1'b0, ACK_READY, 1'b0, 32'h8000_0001},
        {1'b1, ACK_READY, 1'b1, 32'h7FFF_FFFE},
        {1'b0, ACK_ERROR, 1'b1, 32'h0000_0000},
        {1'b1, ACK_RETRY, 1'b0, 32'h0000_0000},
        {1'b0, ACK_ERROR, 1'b1, 32'h0000_0000},
        {1'b1, ACK_WAIT,  1'b0, 32'h0000_0000},
        {1'b1, ACK_READY, 1'b1, 32'h0000_0000},
        {1'b1, ACK_WAIT,  1'b0, 32'h0000_0000},
        {1'b1, ACK_WAIT,  1'b0, 32'h0000_0000},
        {1'b0, ACK_READY, 1'b0, 32'hFFFF_FFFF}
    };

    bus_master_copy_to_tty_unit i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Builds the next bus cycle for a phase. Unless a halt is wanted, the burst, write
    // and status data phases only see wait or ready so that the program keeps running.
    function automatic t_bus_in make_item(logic [4:0] ph, bit to_halt);
        t_bus_in it;
        bit watched;
        it.grant = $urandom_range(99) < 65;
        it.ack_code = 2'($urandom_range(3));
        it.timeout = $urandom_range(3) == 0;
        it.read_data = $urandom;
        watched = (ph >= PH_RAM_FIRST && ph <= PH_RAM_DLAST) || ph == PH_WR_DT || ph == PH_ST_DT;
        if (watched && to_halt) begin
            if ($urandom_range(2) == 0) begin
                it.ack_code = ACK_WAIT;
                it.timeout = 1'b1;
            end else begin
                it.ack_code = $urandom_range(1) ? ACK_ERROR : ACK_RETRY;
            end
        end else if (watched && it.ack_code != ACK_READY) begin
            it.ack_code = ($urandom_range(99) < 55) ? ACK_READY : ACK_WAIT;
            if (it.ack_code == ACK_WAIT) it.timeout = 1'b0;
        end
        if (ph == PH_ST_DT && $urandom_range(1)) it.read_data = '0;
        return it;
    endfunction

    task automatic send_item(input t_bus_in it);
        while (!no_idle && $urandom_range(99) < 31) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_grant <= it.grant;
        i_ack_code <= it.ack_code;
        i_timeout <= it.timeout;
        i_read_data <= it.read_data;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_cycle(it);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_item(make_item(sb.phase_now(), 1'b0));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_register(idx, value);
        @(posedge i_clk);
    endtask

    // Result side: checks every accepted result and stalls at random or on request.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_outputs('{request: o_request, address: o_address, opcode: o_opcode,
                               read_flag: o_read_flag, lock_flag: o_lock_flag,
                               write_data: o_write_data, error_halt: o_error_halt,
                               phase: o_phase});
        end
        if (hold_ask) begin
            hold_left = 80;
            hold_ask = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= no_idle || ($urandom_range(99) >= 31);
        end
    end

    initial begin
        int guard;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // All ones: low address bits must be dropped and the burst wraps past zero.
        write_reg(REG_RAM_BASE, 32'hFFFF_FFFF);
        write_reg(REG_TTY_BASE, 32'hFFFF_FFFF);
        write_reg(REG_WORD_OPCODE, 32'hFFFF_FFFF);
        foreach (opening_seq[k]) send_item(opening_seq[k]);
        run_random(200);
        hold_ask = 1'b1;
        run_random(250);

        wait_drained();
        write_reg(REG_RAM_BASE, 32'h0);
        write_reg(REG_TTY_BASE, 32'h0);
        write_reg(REG_WORD_OPCODE, 32'h0);
        run_random(150);
        no_idle = 1'b1;
        run_random(150);
        no_idle = 1'b0;
        run_random(150);

        wait_drained();
        write_reg(REG_RAM_BASE, $urandom);
        write_reg(REG_TTY_BASE, $urandom);
        write_reg(REG_WORD_OPCODE, $urandom);
        run_random(220);
        wait_drained();
        run_random(230);

        wait_drained();
        write_reg(REG_RAM_BASE, 32'hFFFF_FFF3);
        write_reg(REG_TTY_BASE, 32'hFFFF_FFFA);
        write_reg(REG_WORD_OPCODE, 32'hFFFF_FFF5);
        write_reg(REG_UNUSED, $urandom);
        run_random(430);

        // The halt is sticky until reset, so it is provoked only at the very end.
        guard = 0;
        while (sb.phase_now() != PH_HALT && guard < 200) begin
            send_item(make_item(sb.phase_now(), 1'b1));
            guard++;
        end
        run_random(20);

        wait_drained();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end
endmodule
